// ===== rtl/assert_macros.svh =====
// Assertion macros for the port checker, sao_checker.
// Needs nothing else; take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SAO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SAO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/sao_pkg.sv =====
// Package for the sliding average of norm block: item types, widths,
// controller states and the command/status bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sao_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int COORD_WIDTH = 16;
  localparam int LEN_W       = 7;
  localparam int NORM_W      = COORD_WIDTH;
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int TSUM_W      = TIME_WIDTH + LEN_W;
  localparam int NSUM_W      = NORM_W + LEN_W;
  localparam int ROOT_STEPS  = COORD_WIDTH;
  localparam int DIV_STEPS   = (TSUM_W + 1) / 2;
  localparam int DIV_W       = 2 * DIV_STEPS;
  localparam int CNT_W       = $clog2((ROOT_STEPS > DIV_STEPS) ? ROOT_STEPS : DIV_STEPS);
  localparam int NORM_MAX    = 46340;

  typedef struct packed {
    logic        [TIME_WIDTH-1:0]  time_stamp;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] mean_time;
    logic [NORM_W-1:0]     mean_norm;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUMSQ,
    ST_ROOT,
    ST_UPDATE,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic sumsq;
    logic root_step;
    logic update;
    logic div_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic result_due;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/sao_dp.sv =====
// Datapath: ring stores, running sums, bit-serial square root,
// two-bit-per-cycle divider and output register. Uses sao_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sao_dp #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sao_pkg::in_item_t    in_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [sao_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output sao_pkg::out_item_t        out_data,
  input  wire sao_pkg::cmd_t        cmd,
  output sao_pkg::status_t          stat
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int AW    = ((PTR_W > sao_pkg::LEN_W) ? PTR_W : sao_pkg::LEN_W) + 1;
  localparam int CW    = sao_pkg::COORD_WIDTH;
  localparam int LW    = sao_pkg::LEN_W;

  logic [sao_pkg::TIME_WIDTH-1:0] time_mem [WINDOW_MAX];
  logic [sao_pkg::NORM_W-1:0]     norm_mem [WINDOW_MAX];

  logic [LW-1:0]                  len_r;
  logic [LW-1:0]                  fill_r;
  logic [PTR_W-1:0]               wp_r;
  logic [sao_pkg::TSUM_W-1:0]     tsum_r;
  logic [sao_pkg::NSUM_W-1:0]     nsum_r;
  logic [sao_pkg::TIME_WIDTH-1:0] ts_r;
  logic [CW-1:0]                  mx_r, my_r;
  logic [sao_pkg::SQ_W-1:0]       sqx_r, sqy_r, rad_r;
  logic [CW+1:0]                  rem_r;
  logic [CW-1:0]                  root_r;
  logic [sao_pkg::TIME_WIDTH-1:0] rd_time_r;
  logic [sao_pkg::NORM_W-1:0]     rd_norm_r;
  logic [sao_pkg::DIV_W-1:0]      qt_r, qn_r;
  logic [LW-1:0]                  rt_r, rn_r;
  logic                           out_valid_r;
  sao_pkg::out_item_t             out_data_r;

  logic [LW-1:0]                  n_eff;
  logic [AW-1:0]                  wp_e, n_e, old_e;
  logic [PTR_W-1:0]               old_addr;
  logic [CW-1:0]                  raw_x, raw_y, mx, my;
  logic [CW+1:0]                  rem_sh, trial, rem_nxt;
  logic                           root_ge;
  logic                           sub_old;
  logic [sao_pkg::TSUM_W-1:0]     tsum_nxt;
  logic [sao_pkg::NSUM_W-1:0]     nsum_nxt;
  logic [sao_pkg::DIV_W-1:0]      qt_nxt, qn_nxt;
  logic [LW-1:0]                  rt_nxt, rn_nxt;

  // one restoring step of quotient and remainder
  function automatic logic [sao_pkg::DIV_W+LW-1:0] div_step(
    input logic [sao_pkg::DIV_W-1:0] q,
    input logic [LW-1:0]             r,
    input logic [LW-1:0]             d
  );
    logic [LW:0] tmp;
    logic        ge;
    tmp = {r, q[sao_pkg::DIV_W-1]};
    ge  = (tmp >= {1'b0, d});
    if (ge) begin
      tmp = tmp - {1'b0, d};
    end
    return {q[sao_pkg::DIV_W-2:0], ge, tmp[LW-1:0]};
  endfunction

  always_comb begin
    if (len_r == '0) begin
      n_eff = LW'(1);
    end else if (32'(len_r) > WINDOW_MAX) begin
      n_eff = LW'(WINDOW_MAX);
    end else begin
      n_eff = len_r;
    end
  end

  assign wp_e     = AW'(wp_r);
  assign n_e      = AW'(n_eff);
  assign old_e    = (wp_e >= n_e) ? (wp_e - n_e) : (wp_e + AW'(WINDOW_MAX) - n_e);
  assign old_addr = old_e[PTR_W-1:0];

  assign raw_x = in_data.coord_x;
  assign raw_y = in_data.coord_y;
  assign mx    = raw_x[CW-1] ? (~raw_x + 1'b1) : raw_x;
  assign my    = raw_y[CW-1] ? (~raw_y + 1'b1) : raw_y;

  assign rem_sh  = {rem_r[CW-1:0], rad_r[sao_pkg::SQ_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign root_ge = (rem_sh >= trial);
  assign rem_nxt = root_ge ? (rem_sh - trial) : rem_sh;

  assign sub_old  = (fill_r >= n_eff);
  assign tsum_nxt = tsum_r - (sub_old ? sao_pkg::TSUM_W'(rd_time_r) : '0)
                    + sao_pkg::TSUM_W'(ts_r);
  assign nsum_nxt = nsum_r - (sub_old ? sao_pkg::NSUM_W'(rd_norm_r) : '0)
                    + sao_pkg::NSUM_W'(root_r);

  always_comb begin
    logic [sao_pkg::DIV_W+LW-1:0] st;
    st              = div_step(qt_r, rt_r, n_eff);
    st              = div_step(st[sao_pkg::DIV_W+LW-1:LW], st[LW-1:0], n_eff);
    {qt_nxt, rt_nxt} = st;
    st              = div_step(qn_r, rn_r, n_eff);
    st              = div_step(st[sao_pkg::DIV_W+LW-1:LW], st[LW-1:0], n_eff);
    {qn_nxt, rn_nxt} = st;
  end

  assign stat.result_due = ({1'b0, fill_r} + 1'b1) >= {1'b0, n_eff};
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LW'(1);
      fill_r <= '0;
      wp_r   <= '0;
      tsum_r <= '0;
      nsum_r <= '0;
    end else if (cfg_wr_en) begin
      len_r  <= cfg_wr_data;
      fill_r <= '0;
      wp_r   <= '0;
      tsum_r <= '0;
      nsum_r <= '0;
    end else if (cmd.update) begin
      tsum_r <= tsum_nxt;
      nsum_r <= nsum_nxt;
      wp_r   <= (wp_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r < n_eff) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_time_r <= time_mem[old_addr];
      rd_norm_r <= norm_mem[old_addr];
    end
    if (cmd.update) begin
      time_mem[wp_r] <= ts_r;
      norm_mem[wp_r] <= root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts_r <= in_data.time_stamp;
      mx_r <= mx;
      my_r <= my;
    end
    if (cmd.square) begin
      sqx_r <= sao_pkg::SQ_W'(mx_r) * sao_pkg::SQ_W'(mx_r);
      sqy_r <= sao_pkg::SQ_W'(my_r) * sao_pkg::SQ_W'(my_r);
    end
    if (cmd.sumsq) begin
      rad_r  <= sqx_r + sqy_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= {root_r[CW-2:0], root_ge};
    end
    if (cmd.div_load) begin
      qt_r <= sao_pkg::DIV_W'(tsum_r);
      qn_r <= sao_pkg::DIV_W'(nsum_r);
      rt_r <= '0;
      rn_r <= '0;
    end else if (cmd.div_step) begin
      qt_r <= qt_nxt;
      qn_r <= qn_nxt;
      rt_r <= rt_nxt;
      rn_r <= rn_nxt;
    end
    if (cmd.load_out) begin
      out_data_r.mean_time <= qt_r[sao_pkg::TIME_WIDTH-1:0];
      out_data_r.mean_norm <= qn_r[sao_pkg::NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/sao_ctrl.sv =====
// Controller: sequences capture, square, root, update, divide and
// delivery for one item at a time. Uses sao_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sao_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sao_pkg::status_t stat,
  output sao_pkg::cmd_t         cmd
);

  sao_pkg::state_t             state_r, state_nxt;
  logic [sao_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sao_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = (state_r != sao_pkg::ST_IDLE);
    case (state_r)
      sao_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sao_pkg::ST_SQUARE;
        end
      end
      sao_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = sao_pkg::ST_SUMSQ;
      end
      sao_pkg::ST_SUMSQ: begin
        cmd.sumsq = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sao_pkg::ST_ROOT;
      end
      sao_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == sao_pkg::CNT_W'(sao_pkg::ROOT_STEPS - 1)) begin
          state_nxt = sao_pkg::ST_UPDATE;
        end
      end
      sao_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = stat.result_due ? sao_pkg::ST_DIV_LOAD : sao_pkg::ST_IDLE;
      end
      sao_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sao_pkg::ST_DIVIDE;
      end
      sao_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == sao_pkg::CNT_W'(sao_pkg::DIV_STEPS - 1)) begin
          state_nxt = sao_pkg::ST_DELIVER;
        end
      end
      sao_pkg::ST_DELIVER: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sao_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sao_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sliding_average_of_norm.sv =====
// Top level of the sliding average of norm block: controller and datapath.
// Depends on sao_pkg, sao_ctrl and sao_dp.
//
// One item at a time: an accepted item keeps in_stall high through square,
// sum of squares, square root and update and, when it yields a result,
// also through divider load, divide and delivery; delivery waits only while
// the output register still holds an untaken result. The square root
// retires one root bit per cycle, and the divider retires two quotient bits
// per cycle over the widened timestamp sum. Results wait in an output
// register, so the next item is taken while a result is still stalled. Ring
// stores hold WINDOW_MAX entries each; writing the window length clears the
// window.
`timescale 1ns / 1ps
`default_nettype none

module sliding_average_of_norm #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire sao_pkg::in_item_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output sao_pkg::out_item_t             out_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [sao_pkg::LEN_W-1:0] cfg_wr_data
);

  sao_pkg::cmd_t    cmd;
  sao_pkg::status_t stat;

  sao_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sao_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

// ===== rtl/sao_checker.sv =====
// Port-level checks for sliding_average_of_norm, bound to the top level.
// Depends on sao_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sao_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sao_pkg::out_item_t out_data
);

  // a stalled result item holds
  `SAO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // one item in flight: an accepted item stalls the input next cycle
  `SAO_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // a result only appears at the end of an item's processing
  `SAO_ASSERT_IMPL(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

  // mean of norms cannot exceed the largest norm
  `SAO_ASSERT_IMPL(a_norm_range, clk, rst_n, out_valid, out_data.mean_norm <= sao_pkg::NORM_MAX)

endmodule

bind sliding_average_of_norm sao_checker u_sao_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== dv/sao_window_checker.sv =====
// Checker for sliding_average_of_norm: watches the input, result and window length ports,
// predicts each boxcar average of timestamp and norm, and compares results in order.
// Depends on sao_pkg.
`timescale 1ns / 1ps

module sao_window_checker
  import sao_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  output int        fail_count,
  output int        pending,
  output int        averages_checked,
  output int        samples_taken
);

  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  logic [TIME_WIDTH-1:0] time_ring [RING_DEPTH];
  logic [NORM_W-1:0]     norm_ring [RING_DEPTH];
  logic [TSUM_W-1:0]     time_total;
  logic [NSUM_W-1:0]     norm_total;
  logic [LEN_W-1:0]      len_reg;
  logic [LEN_W-1:0]      fill;
  logic [PTR_W-1:0]      wr_ptr;
  out_item_t             expected_means[$];
  int                    errors;
  int                    averages;
  int                    samples;

  task automatic flag_mismatch(input string what);
    errors++;
    $display("[%0t] average check: %s", $time, what);
  endtask

  function automatic logic [LEN_W-1:0] window_in_force();
    logic [LEN_W-1:0] n;
    n = len_reg;
    if (n == 0) n = LEN_W'(1);
    if (n > RING_DEPTH) n = LEN_W'(RING_DEPTH);
    return n;
  endfunction

  // floor(sqrt(x*x + y*y)), one root bit at a time from the top
  function automatic logic [NORM_W-1:0] norm_of(input logic signed [COORD_WIDTH-1:0] x,
                                                input logic signed [COORD_WIDTH-1:0] y);
    logic [COORD_WIDTH:0] ax, ay;
    logic [SQ_W+1:0]      radicand, trial_sq;
    logic [NORM_W-1:0]    root, trial;
    ax = x[COORD_WIDTH-1] ? ({1'b0, ~x} + (COORD_WIDTH+1)'(1)) : {1'b0, x};
    ay = y[COORD_WIDTH-1] ? ({1'b0, ~y} + (COORD_WIDTH+1)'(1)) : {1'b0, y};
    radicand = (SQ_W+2)'(ax) * (SQ_W+2)'(ax) + (SQ_W+2)'(ay) * (SQ_W+2)'(ay);
    root = '0;
    for (int b = NORM_W - 1; b >= 0; b--) begin
      trial = root | NORM_W'(1 << b);
      trial_sq = (SQ_W+2)'(trial) * (SQ_W+2)'(trial);
      if (trial_sq <= radicand) root = trial;
    end
    return root;
  endfunction

  task automatic take_sample(input in_item_t s);
    logic [LEN_W-1:0]  n;
    logic [NORM_W-1:0] nrm;
    logic [PTR_W-1:0]  oldest;
    logic [TSUM_W-1:0] tq;
    logic [NSUM_W-1:0] nq;
    out_item_t         avg;
    n = window_in_force();
    nrm = norm_of(s.coord_x, s.coord_y);
    if (fill >= n) begin
      oldest = wr_ptr - n[PTR_W-1:0];
      time_total -= TSUM_W'(time_ring[oldest]);
      norm_total -= NSUM_W'(norm_ring[oldest]);
    end
    time_ring[wr_ptr] = s.time_stamp;
    norm_ring[wr_ptr] = nrm;
    time_total += TSUM_W'(s.time_stamp);
    norm_total += NSUM_W'(nrm);
    wr_ptr++;
    if (fill < n) fill++;
    if (fill >= n) begin
      tq = time_total / TSUM_W'(n);
      nq = norm_total / NSUM_W'(n);
      avg.mean_time = tq[TIME_WIDTH-1:0];
      avg.mean_norm = nq[NORM_W-1:0];
      expected_means = {expected_means, avg};
    end
  endtask

  task automatic clear_window();
    time_total = '0;
    norm_total = '0;
    fill = '0;
    wr_ptr = '0;
  endtask

  initial begin
    errors = 0;
    averages = 0;
    samples = 0;
    len_reg = LEN_W'(1);
    clear_window();
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      len_reg = LEN_W'(1);
      clear_window();
      expected_means.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_means.size() == 0) begin
          flag_mismatch($sformatf("unexpected average time=%0d norm=%0d",
                                  out_data.mean_time, out_data.mean_norm));
        end else begin
          want = expected_means.pop_front();
          averages++;
          if (out_data.mean_time !== want.mean_time)
            flag_mismatch($sformatf("average %0d mean_time %0d, want %0d",
                                    averages, out_data.mean_time, want.mean_time));
          if (out_data.mean_norm !== want.mean_norm)
            flag_mismatch($sformatf("average %0d mean_norm %0d, want %0d",
                                    averages, out_data.mean_norm, want.mean_norm));
        end
      end
      if (in_valid && !in_stall) begin
        samples++;
        take_sample(in_data);
      end
      if (cfg_wr_en) begin
        len_reg = cfg_wr_data;
        clear_window();
      end
    end
    fail_count       <= errors;
    pending          <= expected_means.size();
    averages_checked <= averages;
    samples_taken    <= samples;
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the sliding_average_of_norm testbench: clock, reset, stimulus and window length
// writes, random input gaps and output stalls, and the verdict. Depends on sao_pkg,
// sliding_average_of_norm and sao_window_checker.
`timescale 1ns / 1ps

module tb_top;
  import sao_pkg::*;

  localparam int SETTLE      = 45;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL        = 60;
  localparam int NUM_PHASES  = 6;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  int fails, pending, averages, samples;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  logic [TIME_WIDTH-1:0] tick = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sliding_average_of_norm dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  sao_window_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fails),
    .pending          (pending),
    .averages_checked (averages),
    .samples_taken    (samples)
  );

  task automatic send_item(input in_item_t item);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_point(input logic [TIME_WIDTH-1:0] t,
                            input logic signed [COORD_WIDTH-1:0] x,
                            input logic signed [COORD_WIDTH-1:0] y);
    in_item_t item;
    item.time_stamp = t;
    item.coord_x = x;
    item.coord_y = y;
    send_item(item);
  endtask

  // first waits on the clock, so the count includes an item taken at the last edge
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [LEN_W-1:0] len);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] random_coord();
    logic signed [COORD_WIDTH-1:0] c;
    case ($urandom_range(0, 5))
      0: c = 16'sh8000;
      1: c = 16'sh7FFF;
      2: c = COORD_WIDTH'($urandom_range(0, 15) - 8);
      default: c = COORD_WIDTH'($urandom);
    endcase
    return c;
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    case ($urandom_range(0, 4))
      0: s.time_stamp = 32'hFFFF_FFFF - $urandom_range(0, 255);
      1: s.time_stamp = $urandom_range(0, 255);
      2: begin
        tick += $urandom_range(1, 1000);
        s.time_stamp = tick;
      end
      default: s.time_stamp = $urandom;
    endcase
    s.coord_x = random_coord();
    s.coord_y = random_coord();
    return s;
  endfunction

  // receiver: random stall bursts, one long hold-off on request, none once quiet
  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] phase_len [NUM_PHASES];
    int               phase_items [NUM_PHASES];
    phase_len   = '{7'd64, 7'd127, 7'd3, 7'd0, 7'd1, 7'd2};
    phase_items = '{100, 90, 60, 70, 60, 70};
    phase_len[3] = LEN_W'($urandom_range(0, 127));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of one from reset: extremes of time and coordinates, exact squares
    send_point(32'h0000_0000, 16'sh0000, 16'sh0000);
    send_point(32'hFFFF_FFFF, 16'sh8000, 16'sh8000);
    send_point(32'h0000_0001, 16'sh7FFF, 16'sh7FFF);
    send_point(32'hFFFF_FFFE, 16'sh8000, 16'sh7FFF);
    send_point(32'h0000_0007, 16'sh0003, 16'sh0004);
    send_point(32'h0000_0008, -16'sd3, -16'sd4);
    send_point(32'h0000_0009, 16'sh0001, -16'sd1);
    send_point(32'hAAAA_5555, 16'sh0000, 16'sh8000);
    send_point(32'h5555_AAAA, -16'sd1, 16'sh0000);
    send_point(32'h8000_0000, 16'sd12345, -16'sd23456);

    // zero length behaves as one
    set_window(7'd0);
    send_point(32'h0000_0100, 16'sh7FFF, 16'sh8000);
    send_point(32'hFFFF_FFFF, 16'sh0005, 16'sh000C);
    send_point(32'h0000_0102, -16'sd100, 16'sd0);

    // window of two at full scale: the sums run past the field widths
    set_window(7'd2);
    send_point(32'hFFFF_FFFF, 16'sh8000, 16'sh8000);
    send_point(32'hFFFF_FFFF, 16'sh8000, 16'sh8000);
    send_point(32'hFFFF_FFFD, 16'sh7FFF, 16'sh8000);
    send_point(32'h0000_0003, 16'sh0000, 16'sh0001);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_window(phase_len[p]);
      if (phase_len[p] == 7'd3) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      repeat (phase_items[p]) send_item(random_sample());
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL) @(posedge clk);

    $display("Ran %0d samples and checked %0d averages over window lengths 1, 0, 2,",
             samples, averages);
    $display("64, 127, 3, %0d, 1 and 2, with a long result hold-off at length 3.",
             phase_len[3]);
    if (fails == 0) begin
      $display("sliding_average_of_norm regression: pass");
    end else begin
      $display("sliding_average_of_norm regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Run timed out with %0d averages still awaited.", pending);
    $display("sliding_average_of_norm regression: fail");
    $finish;
  end

endmodule
